// ===== sv/ioapic_pkg.sv =====
// ----------------------------------------------------------------------------
// ioapic_pkg
// Shared types and constants for the I/O interrupt controller register block.
// ----------------------------------------------------------------------------
package ioapic_pkg;

    // transaction commands
    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_EDGE  = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    // window offsets
    localparam logic SEL_INDEX  = 1'b0;
    localparam logic SEL_WINDOW = 1'b1;

    // register indexes
    localparam logic [7:0] ID_INDEX      = 8'h00;
    localparam logic [7:0] VERSION_INDEX = 8'h01;
    localparam logic [7:0] TABLE_BASE    = 8'h10;

    // field positions
    localparam int unsigned MASK_BIT_POS = 16;

    // reset value of the version number
    localparam logic [7:0] VERSION_RESET = 8'd32;

    // one result transaction
    typedef struct packed {
        logic [31:0] read_data;
        logic        irq_valid;
        logic [7:0]  irq_vector;
        logic [7:0]  irq_dest;
    } result_t;

endpackage

// ===== sv/ioapic_ram.sv =====
// ----------------------------------------------------------------------------
// ioapic_ram
// One write port, one registered read port, write data forwarded on a
// same-address read.
// ----------------------------------------------------------------------------
module ioapic_ram #(
    parameter int DEPTH  = 24,
    parameter int WIDTH  = 8,
    parameter int ADDR_W = 5
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // read port with write-through on address match
    always_ff @(posedge aclk) begin
        if (re) begin
            if (we && (waddr == raddr)) begin
                rdata_reg <= wdata;
            end else begin
                rdata_reg <= mem[raddr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/ioapic_out_stage.sv =====
// ----------------------------------------------------------------------------
// ioapic_out_stage
// Result register holding one finished transaction until the sink takes it.
// ----------------------------------------------------------------------------
module ioapic_out_stage
    import ioapic_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        load,
    input  result_t     result,
    output logic        free,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_read_data,
    output logic        m_irq_valid,
    output logic [7:0]  m_irq_vector,
    output logic [7:0]  m_irq_dest
);

    logic    valid_reg;
    result_t data_reg;

    // space for a new result when empty or being drained
    assign free = !valid_reg || m_ready;

    // valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= result;
        end
    end

    assign m_valid      = valid_reg;
    assign m_read_data  = data_reg.read_data;
    assign m_irq_valid  = data_reg.irq_valid;
    assign m_irq_vector = data_reg.irq_vector;
    assign m_irq_dest   = data_reg.irq_dest;

endmodule

// ===== sv/io_apic_redirection_registers.sv =====
// ----------------------------------------------------------------------------
// io_apic_redirection_registers
// Indirect register window of an I/O interrupt controller with a per-pin
// redirection table and fixed-mode edge delivery.
// ----------------------------------------------------------------------------
// Stages: input register with entry memory read, then decode and result
// register. Throughput: one transaction per cycle while the sink is ready
// or the result register is empty; the entry memory read port and the
// result register each handle one transaction a cycle.
// Reset: synchronous active low; index, ID, pipeline valids and per-entry
// written flags cleared, every mask bit set, version number back to 32.
// ----------------------------------------------------------------------------
module io_apic_redirection_registers
    import ioapic_pkg::*;
#(
    parameter int NUM_PINS = 24
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data,
    // input transactions
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_cmd,
    input  logic        s_window_select,
    input  logic [31:0] s_write_data,
    input  logic [4:0]  s_pin,
    // result transactions
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_read_data,
    output logic        m_irq_valid,
    output logic [7:0]  m_irq_vector,
    output logic [7:0]  m_irq_dest
);

    localparam int SLOT_W = (NUM_PINS > 1) ? $clog2(NUM_PINS) : 1;
    localparam logic [7:0] MAX_ENTRY = 8'(NUM_PINS - 1);

    // configuration register
    logic [7:0] version_reg;

    // architectural state
    logic [7:0]          index_reg;
    logic [3:0]          id_reg;
    logic [NUM_PINS-1:0] mask_reg;

    // entries whose vector or destination has been written since reset
    logic [NUM_PINS-1:0] vec_set_reg;
    logic [NUM_PINS-1:0] dest_set_reg;

    // input register
    logic        in_valid_reg;
    cmd_t        in_cmd_reg;
    logic        in_sel_reg;
    logic [31:0] in_wdata_reg;
    logic [4:0]  in_pin_reg;

    // handshake
    logic    advance;
    logic    out_free;
    logic    accept;
    result_t result;

    // memory ports
    logic              vec_we;
    logic              dest_we;
    logic [SLOT_W-1:0] waddr;
    logic [SLOT_W-1:0] raddr;
    logic [7:0]        vec_rdata;
    logic [7:0]        dest_rdata;

    // decode of the current index
    logic [7:0]        idx_diff;
    logic [6:0]        idx_slot;
    logic              idx_in_table;
    logic [SLOT_W-1:0] slot;

    // pin of the transaction in execution
    logic [6:0]        pin_slot;
    logic [SLOT_W-1:0] pin_idx;

    // decode of the read address at input time
    logic [7:0] eff_index;
    logic [7:0] eff_diff;
    logic [6:0] eff_slot;
    logic [6:0] rd_slot;

    // next-state values
    logic [7:0]          index_next;
    logic [3:0]          id_next;
    logic [NUM_PINS-1:0] mask_next;
    logic [NUM_PINS-1:0] vec_set_next;
    logic [NUM_PINS-1:0] dest_set_next;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            version_reg <= VERSION_RESET;
        end else if (cfg_valid) begin
            version_reg <= cfg_data;
        end
    end

    // pipeline control
    assign advance = in_valid_reg && out_free;
    assign s_ready = !in_valid_reg || advance;
    assign accept  = s_valid && s_ready;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            in_cmd_reg   <= cmd_t'(s_cmd);
            in_sel_reg   <= s_window_select;
            in_wdata_reg <= s_write_data;
            in_pin_reg   <= s_pin;
        end
    end

    // read address: index as left by the transaction ahead, or the pin
    always_comb begin
        if (in_valid_reg && (in_cmd_reg == CMD_WRITE) && (in_sel_reg == SEL_INDEX)) begin
            eff_index = in_wdata_reg[7:0];
        end else begin
            eff_index = index_reg;
        end
        eff_diff = eff_index - TABLE_BASE;
        eff_slot = eff_diff[7:1];
        if (cmd_t'(s_cmd) == CMD_EDGE) begin
            rd_slot = {2'b00, s_pin};
        end else begin
            rd_slot = eff_slot;
        end
        raddr = rd_slot[SLOT_W-1:0];
    end

    // decode of the index for the transaction in execution
    assign idx_diff     = index_reg - TABLE_BASE;
    assign idx_slot     = idx_diff[7:1];
    assign idx_in_table = (index_reg >= TABLE_BASE) && (32'(idx_slot) < NUM_PINS);
    assign slot         = idx_slot[SLOT_W-1:0];
    assign waddr        = slot;
    assign pin_slot     = {2'b00, in_pin_reg};
    assign pin_idx      = pin_slot[SLOT_W-1:0];

    // execute: state update and result
    always_comb begin
        index_next    = index_reg;
        id_next       = id_reg;
        mask_next     = mask_reg;
        vec_set_next  = vec_set_reg;
        dest_set_next = dest_set_reg;
        vec_we        = 1'b0;
        dest_we       = 1'b0;
        result        = '0;
        unique case (in_cmd_reg)
            CMD_WRITE: begin
                if (in_sel_reg == SEL_INDEX) begin
                    index_next = in_wdata_reg[7:0];
                end else if (index_reg == ID_INDEX) begin
                    id_next = in_wdata_reg[27:24];
                end else if (idx_in_table) begin
                    if (!idx_diff[0]) begin
                        mask_next[slot]    = in_wdata_reg[MASK_BIT_POS];
                        vec_set_next[slot] = 1'b1;
                        vec_we             = advance;
                    end else begin
                        dest_set_next[slot] = 1'b1;
                        dest_we             = advance;
                    end
                end
            end
            CMD_READ: begin
                if (in_sel_reg == SEL_INDEX) begin
                    result.read_data = {24'd0, index_reg};
                end else if (index_reg == ID_INDEX) begin
                    result.read_data = {4'd0, id_reg, 24'd0};
                end else if (index_reg == VERSION_INDEX) begin
                    result.read_data = {8'd0, MAX_ENTRY, 8'd0, version_reg};
                end else if (idx_in_table) begin
                    if (!idx_diff[0]) begin
                        result.read_data = {15'd0, mask_reg[slot], 8'd0,
                                            vec_set_reg[slot] ? vec_rdata : 8'd0};
                    end else begin
                        result.read_data = {dest_set_reg[slot] ? dest_rdata : 8'd0, 24'd0};
                    end
                end
            end
            CMD_EDGE: begin
                if ((32'(in_pin_reg) < NUM_PINS) && !mask_reg[pin_idx]) begin
                    result.irq_valid  = 1'b1;
                    result.irq_vector = vec_set_reg[pin_idx] ? vec_rdata : 8'd0;
                    result.irq_dest   = dest_set_reg[pin_idx] ? dest_rdata : 8'd0;
                end
            end
            default: begin
                result = '0;
            end
        endcase
    end

    // architectural state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            index_reg    <= '0;
            id_reg       <= '0;
            mask_reg     <= '1;
            vec_set_reg  <= '0;
            dest_set_reg <= '0;
        end else if (advance) begin
            index_reg    <= index_next;
            id_reg       <= id_next;
            mask_reg     <= mask_next;
            vec_set_reg  <= vec_set_next;
            dest_set_reg <= dest_set_next;
        end
    end

    // redirection entry vectors
    ioapic_ram #(
        .DEPTH  (NUM_PINS),
        .WIDTH  (8),
        .ADDR_W (SLOT_W)
    ) u_vec_ram (
        .aclk  (aclk),
        .we    (vec_we),
        .waddr (waddr),
        .wdata (in_wdata_reg[7:0]),
        .re    (accept),
        .raddr (raddr),
        .rdata (vec_rdata)
    );

    // redirection entry destinations
    ioapic_ram #(
        .DEPTH  (NUM_PINS),
        .WIDTH  (8),
        .ADDR_W (SLOT_W)
    ) u_dest_ram (
        .aclk  (aclk),
        .we    (dest_we),
        .waddr (waddr),
        .wdata (in_wdata_reg[31:24]),
        .re    (accept),
        .raddr (raddr),
        .rdata (dest_rdata)
    );

    // result register
    ioapic_out_stage u_out_stage (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .load         (advance),
        .result       (result),
        .free         (out_free),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_read_data  (m_read_data),
        .m_irq_valid  (m_irq_valid),
        .m_irq_vector (m_irq_vector),
        .m_irq_dest   (m_irq_dest)
    );

endmodule
